// ===== rtl/core/ntdd_pkg.sv =====
`timescale 1ns / 1ps

package ntdd_pkg;

    // Request modes
    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BIN  = 2'd3
    } op_t;

    // Result item kinds
    localparam logic KIND_CURSOR = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    // ASCII codes
    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_PLUS    = 7'h2B;
    localparam logic [6:0] CHAR_MINUS   = 7'h2D;
    localparam logic [6:0] CHAR_NONE    = 7'h00;

    // Digit limits per mode and display geometry
    localparam logic [5:0] MAX_DEC_LEN   = 6'd10;
    localparam logic [5:0] MAX_HEX_LEN   = 6'd8;
    localparam logic [5:0] DISPLAY_COLS  = 6'd16;
    localparam logic [5:0] DISPLAY_CELLS = 6'd32;

    // BCD accumulator size: ten decimal digits cover any 32-bit magnitude
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CONV = 6'b000010,
        ST_CUR  = 6'b000100,
        ST_SIGN = 6'b001000,
        ST_DIG  = 6'b010000,
        ST_CUR2 = 6'b100000
    } state_t;

endpackage

// ===== rtl/core/number_to_display_digits_unit.sv =====
`timescale 1ns / 1ps
// Number to display digits converter.
// The s_ channel takes one request: a mode (unsigned decimal, signed decimal,
// upper-case hex, binary), a start line and column, a number and a digit count.
// The m_ channel returns a set-cursor command followed by fixed-length ASCII
// digits, most significant first; m_last marks the final item of a request.
// Signed decimal always leads with '+' or '-'. Binary runs over 16 digits are
// split across both lines with a second set-cursor command.
// Hex and binary requests go straight to the set-cursor command. Decimal
// modes first run a shift-and-add-3 BCD converter that takes one number
// bit per cycle, and queue the first item only once it is done.
// Throughput: one result item per cycle while items are emitted and m_ready
// is high. A request queues a set-cursor command, a sign in signed decimal,
// the clamped count of digits and, in a split binary run, a second
// set-cursor command. A new request is taken once the final item has
// reached the output register, even while it still waits there.
// Reset clears the sequencer and drops any pending output item.
// A receiver stall holds the output register and the emitting states.

module number_to_display_digits_unit #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic        s_line,
    input  logic [3:0]  s_col,
    input  logic [31:0] s_number,
    input  logic [5:0]  s_length,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic        m_cursor_line,
    output logic [3:0]  m_cursor_col,
    output logic [6:0]  m_char_code,
    output logic        m_last
);

    localparam int NW    = NUMBER_WIDTH;
    localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);
    localparam logic [5:0] MAX_BIN_LEN = 6'(NUMBER_WIDTH);

    ntdd_pkg::state_t state_reg, state_next;

    logic [1:0]               op_reg, op_next;
    logic                     line_reg, line_next;
    logic [3:0]               col_reg, col_next;
    logic [5:0]               len_reg, len_next;
    logic [5:0]               low_reg, low_next;
    logic                     split_reg, split_next;
    logic                     neg_reg, neg_next;
    logic [NW-1:0]            value_reg, value_next;
    logic [ntdd_pkg::BCD_W-1:0] bcd_reg, bcd_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [5:0]               idx_reg, idx_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     m_kind_reg;
    logic                     m_line_reg;
    logic [3:0]               m_col_reg;
    logic [6:0]               m_char_reg;
    logic                     m_last_reg;

    // Request decode
    logic                     accept;
    logic [5:0]               len_max;
    logic [5:0]               len_clamped;
    logic [5:0]               room;
    logic [3:0]               col_fit;
    logic                     split_in;
    logic [NW-1:0]            val_in;
    logic                     neg_in;
    logic [NW-1:0]            mag_in;

    // Emission
    logic                     emit_valid;
    logic                     load;
    logic                     e_kind;
    logic                     e_line;
    logic [3:0]               e_col;
    logic [6:0]               e_char;
    logic                     e_last;
    ntdd_pkg::state_t         e_state;
    logic [5:0]               e_idx;
    logic [5:0]               pos;
    logic [31:0]              hex_word;
    logic [3:0]               dec_digit;
    logic [3:0]               hex_digit;
    logic [ntdd_pkg::BCD_W-1:0] bcd_adj;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ntdd_pkg::ST_IDLE);

    // Clamp the digit count to the mode's maximum
    always_comb begin
        case (ntdd_pkg::op_t'(s_op))
            ntdd_pkg::OP_UDEC: len_max = ntdd_pkg::MAX_DEC_LEN;
            ntdd_pkg::OP_SDEC: len_max = ntdd_pkg::MAX_DEC_LEN;
            ntdd_pkg::OP_HEX:  len_max = ntdd_pkg::MAX_HEX_LEN;
            default:           len_max = MAX_BIN_LEN;
        endcase
    end

    assign len_clamped = (s_length > len_max) ? len_max : s_length;

    // Fit a long binary run into both lines
    assign split_in = (ntdd_pkg::op_t'(s_op) == ntdd_pkg::OP_BIN)
                      && (len_clamped > ntdd_pkg::DISPLAY_COLS);
    assign room     = ntdd_pkg::DISPLAY_CELLS - len_clamped;
    assign col_fit  = ({2'b00, s_col} > room) ? room[3:0] : s_col;

    // Take the magnitude in signed mode
    assign val_in = s_number[NW-1:0];
    assign neg_in = (ntdd_pkg::op_t'(s_op) == ntdd_pkg::OP_SDEC) && val_in[NW-1];
    assign mag_in = neg_in ? NW'(~val_in + 1'b1) : val_in;

    // Add 3 to every BCD digit of 5 or more before the next shift
    always_comb begin
        bcd_adj = bcd_reg;
        for (int d = 0; d < ntdd_pkg::BCD_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
        end
    end

    // Pick the digit at the current position
    assign pos       = idx_reg - 6'd1;
    assign hex_word  = 32'(value_reg);
    assign dec_digit = bcd_reg[{pos[3:0], 2'b00} +: 4];
    assign hex_digit = hex_word[{pos[2:0], 2'b00} +: 4];

    // Build the next result item
    always_comb begin
        emit_valid = 1'b0;
        e_kind     = ntdd_pkg::KIND_CHAR;
        e_line     = 1'b0;
        e_col      = 4'd0;
        e_char     = ntdd_pkg::CHAR_NONE;
        e_last     = 1'b0;
        e_state    = state_reg;
        e_idx      = idx_reg;
        case (state_reg)
            ntdd_pkg::ST_CUR: begin
                emit_valid = 1'b1;
                e_kind     = ntdd_pkg::KIND_CURSOR;
                e_line     = line_reg;
                e_col      = col_reg;
                if (ntdd_pkg::op_t'(op_reg) == ntdd_pkg::OP_SDEC) begin
                    e_state = ntdd_pkg::ST_SIGN;
                end else if (len_reg == 6'd0) begin
                    e_last  = 1'b1;
                    e_state = ntdd_pkg::ST_IDLE;
                end else begin
                    e_state = ntdd_pkg::ST_DIG;
                end
            end
            ntdd_pkg::ST_SIGN: begin
                emit_valid = 1'b1;
                e_char     = neg_reg ? ntdd_pkg::CHAR_MINUS : ntdd_pkg::CHAR_PLUS;
                if (len_reg == 6'd0) begin
                    e_last  = 1'b1;
                    e_state = ntdd_pkg::ST_IDLE;
                end else begin
                    e_state = ntdd_pkg::ST_DIG;
                end
            end
            ntdd_pkg::ST_DIG: begin
                emit_valid = 1'b1;
                case (ntdd_pkg::op_t'(op_reg))
                    ntdd_pkg::OP_UDEC: e_char = ntdd_pkg::CHAR_ZERO + 7'(dec_digit);
                    ntdd_pkg::OP_SDEC: e_char = ntdd_pkg::CHAR_ZERO + 7'(dec_digit);
                    ntdd_pkg::OP_HEX: begin
                        if (hex_digit < 4'd10) begin
                            e_char = ntdd_pkg::CHAR_ZERO + 7'(hex_digit);
                        end else begin
                            e_char = ntdd_pkg::CHAR_UPPER_A + 7'(hex_digit - 4'd10);
                        end
                    end
                    default: e_char = ntdd_pkg::CHAR_ZERO + 7'(hex_word[pos[4:0]]);
                endcase
                e_idx = pos;
                if (pos == 6'd0) begin
                    e_last  = 1'b1;
                    e_state = ntdd_pkg::ST_IDLE;
                end else if (split_reg && (pos == low_reg)) begin
                    e_state = ntdd_pkg::ST_CUR2;
                end
            end
            ntdd_pkg::ST_CUR2: begin
                emit_valid = 1'b1;
                e_kind     = ntdd_pkg::KIND_CURSOR;
                e_line     = 1'b1;
                e_col      = 4'd0;
                e_state    = ntdd_pkg::ST_DIG;
            end
            default: begin
                emit_valid = 1'b0;
            end
        endcase
    end

    assign load = emit_valid && (!m_valid_reg || m_ready);

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        len_next   = len_reg;
        low_next   = low_reg;
        split_next = split_reg;
        neg_next   = neg_reg;
        value_next = value_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ntdd_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next    = s_op;
                    line_next  = split_in ? 1'b0 : s_line;
                    col_next   = split_in ? col_fit : s_col;
                    len_next   = len_clamped;
                    low_next   = len_clamped - ntdd_pkg::DISPLAY_COLS + {2'b00, col_fit};
                    split_next = split_in;
                    neg_next   = neg_in;
                    value_next = mag_in;
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(NUMBER_WIDTH);
                    idx_next   = len_clamped;
                    if ((ntdd_pkg::op_t'(s_op) == ntdd_pkg::OP_UDEC)
                        || (ntdd_pkg::op_t'(s_op) == ntdd_pkg::OP_SDEC)) begin
                        state_next = ntdd_pkg::ST_CONV;
                    end else begin
                        state_next = ntdd_pkg::ST_CUR;
                    end
                end
            end
            ntdd_pkg::ST_CONV: begin
                // Shift one magnitude bit into the BCD register
                bcd_next   = {bcd_adj[ntdd_pkg::BCD_W-2:0], value_reg[NW-1]};
                value_next = {value_reg[NW-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ntdd_pkg::ST_CUR;
                end
            end
            default: begin
                if (load) begin
                    state_next = e_state;
                    idx_next   = e_idx;
                end
            end
        endcase
    end

    // Output register: hold while stalled, drop when taken
    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ntdd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        line_reg  <= line_next;
        col_reg   <= col_next;
        len_reg   <= len_next;
        low_reg   <= low_next;
        split_reg <= split_next;
        neg_reg   <= neg_next;
        value_reg <= value_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        if (load) begin
            m_kind_reg <= e_kind;
            m_line_reg <= e_line;
            m_col_reg  <= e_col;
            m_char_reg <= e_char;
            m_last_reg <= e_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_cursor_line = m_line_reg;
    assign m_cursor_col  = m_col_reg;
    assign m_char_code   = m_char_reg;
    assign m_last        = m_last_reg;

    // A request blocks further requests until its last item is queued
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while another is in progress");

    // Digit emission never runs past position zero
    a_dig_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ntdd_pkg::ST_DIG) |-> (idx_reg != 6'd0))
        else $error("digit index underflow");

    // The second cursor command only appears in a split binary run
    a_cur2_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ntdd_pkg::ST_CUR2)
        |-> (split_reg && (op_reg == ntdd_pkg::OP_BIN) && (low_reg < len_reg)))
        else $error("second cursor outside a split binary run");

    // The sequencer returns to idle exactly when it queues a last item
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && e_last) |=> (state_reg == ntdd_pkg::ST_IDLE) && m_valid && m_last)
        else $error("last item not followed by idle");

endmodule
